FILE: rtl/core/dgt_pkg.sv
// ----------------------------------------------------------------------------
// dgt_pkg: shared types and constants of the delimiter/group tokenizer
// Holds capacity limits, register indexes and the action record passed from
// the classifier to the result sequencer.
// ----------------------------------------------------------------------------
package dgt_pkg;

    // Capacity of the delimiter and group tables
    localparam int MAX_DELIMS = 8;
    localparam int MAX_GROUPS = 4;
    localparam int DELIM_LIM  = (MAX_DELIMS < 8) ? MAX_DELIMS : 8;
    localparam int GROUP_LIM  = (MAX_GROUPS < 4) ? MAX_GROUPS : 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_CHARS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_CHARS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_CHARS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_COUNT = 3'd5;

    // Action queue between classifier and sequencer
    localparam int ACT_DEPTH = 4;
    localparam int ACT_PTR_W = $clog2(ACT_DEPTH);
    localparam int ACT_CNT_W = $clog2(ACT_DEPTH + 1);

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // One classified item: an optional token byte, then an optional token end
    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       has_end;
    } act_t;

endpackage

FILE: rtl/core/dgt_front.sv
// ----------------------------------------------------------------------------
// dgt_front: configuration registers and byte classifier
// Matches each accepted byte against the delimiter, opener and close tables,
// updates the tokenizer state and issues at most one action record per item.
// ----------------------------------------------------------------------------
module dgt_front
    import dgt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_wr_t    cfg,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       last,
    output logic       act_valid,
    output act_t       act
);

    logic [63:0] delim_chars_reg;
    logic [3:0]  delim_count_reg;
    logic [31:0] open_chars_reg;
    logic [2:0]  open_count_reg;
    logic [31:0] close_chars_reg;
    logic [2:0]  close_count_reg;

    logic       in_group_reg, in_group_next;
    logic       after_delim_reg, after_delim_next;
    logic [1:0] group_sel_reg, group_sel_next;
    logic       token_nonempty_reg, token_nonempty_next;

    logic [3:0] delim_eff;
    logic [2:0] open_eff;
    logic [2:0] close_eff;
    logic       delim_hit;
    logic       is_open;
    logic [1:0] open_idx;
    logic [7:0] close_byte;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_chars_reg <= '0;
            delim_count_reg <= '0;
            open_chars_reg  <= '0;
            open_count_reg  <= '0;
            close_chars_reg <= '0;
            close_count_reg <= '0;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                REG_DELIM_CHARS: delim_chars_reg <= cfg.data;
                REG_DELIM_COUNT: delim_count_reg <= cfg.data[3:0];
                REG_OPEN_CHARS:  open_chars_reg  <= cfg.data[31:0];
                REG_OPEN_COUNT:  open_count_reg  <= cfg.data[2:0];
                REG_CLOSE_CHARS: close_chars_reg <= cfg.data[31:0];
                REG_CLOSE_COUNT: close_count_reg <= cfg.data[2:0];
                default: ;
            endcase
        end
    end

    // Clamp counts to table capacity
    always_comb
    begin
        delim_eff = (delim_count_reg > 4'(DELIM_LIM)) ? 4'(DELIM_LIM) : delim_count_reg;
        open_eff  = (open_count_reg > 3'(GROUP_LIM)) ? 3'(GROUP_LIM) : open_count_reg;
        close_eff = (close_count_reg > 3'(GROUP_LIM)) ? 3'(GROUP_LIM) : close_count_reg;
    end

    // Match the byte against the enabled delimiter and opener entries in parallel
    always_comb
    begin
        delim_hit = 1'b0;
        for (int k = 0; k < DELIM_LIM; k++)
        begin
            if ((4'(k) < delim_eff) && (delim_chars_reg[k*8 +: 8] == in_byte))
                delim_hit = 1'b1;
        end
        // scan downward so the lowest matching opener wins
        is_open  = 1'b0;
        open_idx = '0;
        for (int k = GROUP_LIM - 1; k >= 0; k--)
        begin
            if ((3'(k) < open_eff) && (open_chars_reg[k*8 +: 8] == in_byte))
            begin
                is_open  = 1'b1;
                open_idx = 2'(k);
            end
        end
        // a group without a close entry closes on a zero byte
        if ({1'b0, group_sel_reg} < close_eff)
            close_byte = close_chars_reg[group_sel_reg*8 +: 8];
        else
            close_byte = 8'h00;
    end

    // Advance tokenizer state and build the action record
    always_comb
    begin
        in_group_next       = in_group_reg;
        after_delim_next    = after_delim_reg;
        group_sel_next      = group_sel_reg;
        token_nonempty_next = token_nonempty_reg;
        act.has_data        = 1'b0;
        act.data            = in_byte;
        act.has_end         = 1'b0;

        if (!in_group_reg)
        begin
            if (delim_hit)
            begin
                if (!after_delim_reg)
                begin
                    act.has_end         = 1'b1;
                    token_nonempty_next = 1'b0;
                    after_delim_next    = 1'b1;
                end
            end
            else
            begin
                after_delim_next = 1'b0;
            end
            if (is_open)
            begin
                in_group_next    = 1'b1;
                group_sel_next   = open_idx;
                after_delim_next = 1'b1;
            end
            else if (!after_delim_next)
            begin
                act.has_data        = 1'b1;
                token_nonempty_next = 1'b1;
            end
        end
        else
        begin
            if (in_byte == close_byte)
            begin
                act.has_end         = 1'b1;
                token_nonempty_next = 1'b0;
                in_group_next       = 1'b0;
                group_sel_next      = '0;
            end
            else
            begin
                act.has_data        = 1'b1;
                token_nonempty_next = 1'b1;
            end
        end

        // flush a pending token at end of string, then start fresh
        if (last)
        begin
            if (token_nonempty_next)
                act.has_end = 1'b1;
            in_group_next       = 1'b0;
            after_delim_next    = 1'b0;
            group_sel_next      = '0;
            token_nonempty_next = 1'b0;
        end

        act_valid = accept && (act.has_data || act.has_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_group_reg       <= 1'b0;
            after_delim_reg    <= 1'b0;
            group_sel_reg      <= '0;
            token_nonempty_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_group_reg       <= in_group_next;
            after_delim_reg    <= after_delim_next;
            group_sel_reg      <= group_sel_next;
            token_nonempty_reg <= token_nonempty_next;
        end
    end

endmodule

FILE: rtl/core/dgt_queue.sv
// ----------------------------------------------------------------------------
// dgt_queue: action record queue
// Short queue that decouples the classifier from the result sequencer.
// ----------------------------------------------------------------------------
module dgt_queue
    import dgt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  act_t wr_data,
    input  logic rd_en,
    output act_t rd_data,
    output logic full,
    output logic empty
);

    act_t                 entry_reg [ACT_DEPTH];
    logic [ACT_PTR_W-1:0] wr_ptr_reg;
    logic [ACT_PTR_W-1:0] rd_ptr_reg;
    logic [ACT_CNT_W-1:0] count_reg;

    assign full    = (count_reg == ACT_CNT_W'(ACT_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Store incoming records
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == ACT_PTR_W'(ACT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == ACT_PTR_W'(ACT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/dgt_back.sv
// ----------------------------------------------------------------------------
// dgt_back: result sequencer
// Expands each action record into one or two result items and holds the
// oldest result in an output register until it is popped.
// ----------------------------------------------------------------------------
module dgt_back
    import dgt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  act_t       act,
    input  logic       act_empty,
    output logic       act_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       token_end,
    output logic       last_result
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       token_end_reg, token_end_next;
    logic       last_result_reg, last_result_next;
    logic       phase_reg, phase_next;
    logic       load;

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign token_end   = token_end_reg;
    assign last_result = last_result_reg;

    // Pick the next result from the head record
    always_comb
    begin
        load             = (!out_valid_reg || pop) && !act_empty;
        act_pop          = 1'b0;
        phase_next       = phase_reg;
        out_byte_next    = 8'h00;
        token_end_next   = 1'b1;
        last_result_next = 1'b1;
        if (!phase_reg && act.has_data)
        begin
            out_byte_next    = act.data;
            token_end_next   = 1'b0;
            last_result_next = !act.has_end;
            if (load)
            begin
                if (act.has_end)
                    phase_next = 1'b1;
                else
                    act_pop = 1'b1;
            end
        end
        else if (load)
        begin
            act_pop    = 1'b1;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= out_byte_next;
            token_end_reg   <= token_end_next;
            last_result_reg <= last_result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/delimiter_group_tokenizer.sv
// ----------------------------------------------------------------------------
// delimiter_group_tokenizer: byte stream tokenizer with delimiter groups
// Path: an accepted item's action record enters the queue at the accept edge;
//   its results then pass through the output register when that is free or popped.
// Throughput: one item per cycle while full is low; the sequencer gives one result
//   per free output slot, two for a data-plus-end record; full rises at 4 records.
// Reset: rst_n clears configuration, tokenizer state, queue and output.
// ----------------------------------------------------------------------------
module delimiter_group_tokenizer
    import dgt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            in_byte,
    input  logic                  last,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_byte,
    output logic                  token_end,
    output logic                  last_result
);

    cfg_wr_t cfg;
    logic    accept;
    logic    act_valid;
    act_t    act_in;
    act_t    act_head;
    logic    act_pop;
    logic    act_empty;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign accept    = push && !full;

    // Classify bytes
    dgt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .in_byte   (in_byte),
        .last      (last),
        .act_valid (act_valid),
        .act       (act_in)
    );

    // Buffer action records
    dgt_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (act_valid),
        .wr_data (act_in),
        .rd_en   (act_pop),
        .rd_data (act_head),
        .full    (full),
        .empty   (act_empty)
    );

    // Emit result items
    dgt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .act         (act_head),
        .act_empty   (act_empty),
        .act_pop     (act_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .token_end   (token_end),
        .last_result (last_result)
    );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the delimiter/group tokenizer
// Drives byte strings through the push/full side under several delimiter and
// group settings. A behavioral tokenizer predicts every result, and the
// pop/empty side is checked field by field against the oldest prediction.
// Both sides idle at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import dgt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int IDLE_PCT      = 16;
    localparam int PHASE_BYTES   = 93;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 40;

    // Register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       tend;
        logic       final_res;
    } token_res_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [7:0]            in_byte   = 8'h00;
    logic                  last      = 1'b0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [7:0]            out_byte;
    logic                  token_end;
    logic                  last_result;

    // Shadow copy of the configuration
    logic [63:0] sep_set     = '0;
    logic [3:0]  sep_cnt     = '0;
    logic [31:0] opener_set  = '0;
    logic [2:0]  opener_cnt  = '0;
    logic [31:0] closer_set  = '0;
    logic [2:0]  closer_cnt  = '0;

    // Tokenizer state of the predictor
    logic        grp_active  = 1'b0;
    logic        delim_run   = 1'b0;
    logic [1:0]  grp_idx     = 2'd0;
    logic        tok_pending = 1'b0;

    token_res_t  pending_tokens[$];
    token_res_t  head_token;

    int          error_count = 0;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          tx_idle_pct = IDLE_PCT;
    int          rx_idle_pct = IDLE_PCT;
    int          rx_hold     = 0;

    delimiter_group_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .last        (last),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .token_end   (token_end),
        .last_result (last_result)
    );

    always #CLK_HALF clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Predict the results of one accepted byte and queue them
    function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
        token_res_t res [3];
        int         n;
        int         n_sep;
        int         n_open;
        int         n_close;
        int         grp;
        logic       is_sep;
        logic [7:0] closer;

        n       = 0;
        n_sep   = (sep_cnt > DELIM_LIM) ? DELIM_LIM : int'(sep_cnt);
        n_open  = (opener_cnt > GROUP_LIM) ? GROUP_LIM : int'(opener_cnt);
        n_close = (closer_cnt > GROUP_LIM) ? GROUP_LIM : int'(closer_cnt);

        if (!grp_active)
        begin
            is_sep = 1'b0;
            for (int k = 0; k < n_sep; k++)
                if (sep_set[k*8 +: 8] == b)
                    is_sep = 1'b1;
            // First delimiter of a run ends the token, the rest are skipped
            if (is_sep)
            begin
                if (!delim_run)
                begin
                    res[n] = {8'h00, 1'b1, 1'b0};
                    n++;
                    tok_pending = 1'b0;
                    delim_run   = 1'b1;
                end
            end
            else
                delim_run = 1'b0;
            // Lowest matching opener wins
            grp = -1;
            for (int k = n_open - 1; k >= 0; k--)
                if (opener_set[k*8 +: 8] == b)
                    grp = k;
            if (grp >= 0)
            begin
                grp_active = 1'b1;
                grp_idx    = grp[1:0];
                delim_run  = 1'b1;
            end
            else if (!delim_run)
            begin
                res[n] = {b, 1'b0, 1'b0};
                n++;
                tok_pending = 1'b1;
            end
        end
        else
        begin
            // Groups past the close count close on a zero byte
            closer = (grp_idx < n_close) ? closer_set[grp_idx*8 +: 8] : 8'h00;
            if (b == closer)
            begin
                res[n] = {8'h00, 1'b1, 1'b0};
                n++;
                tok_pending = 1'b0;
                grp_active  = 1'b0;
                grp_idx     = 2'd0;
            end
            else
            begin
                res[n] = {b, 1'b0, 1'b0};
                n++;
                tok_pending = 1'b1;
            end
        end

        // End of string: flush a nonempty token and clear the state
        if (fin)
        begin
            if (tok_pending)
            begin
                res[n] = {8'h00, 1'b1, 1'b0};
                n++;
            end
            grp_active  = 1'b0;
            delim_run   = 1'b0;
            grp_idx     = 2'd0;
            tok_pending = 1'b0;
        end

        for (int i = 0; i < n; i++)
        begin
            res[i].final_res = (i == n - 1);
            pending_tokens.push_back(res[i]);
        end
    endfunction

    // Pop results at random and check each against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_tokens.size() == 0)
                flag_error($sformatf("unexpected result out_byte=%02h token_end=%0b",
                                     out_byte, token_end));
            else
            begin
                head_token = pending_tokens.pop_front();
                if (out_byte !== head_token.data)
                    flag_error($sformatf("out_byte got %02h want %02h",
                                         out_byte, head_token.data));
                if (token_end !== head_token.tend)
                    flag_error($sformatf("token_end got %0b want %0b",
                                         token_end, head_token.tend));
                if (last_result !== head_token.final_res)
                    flag_error($sformatf("last_result got %0b want %0b",
                                         last_result, head_token.final_res));
            end
        end
        if (rx_hold > 0)
        begin
            pop <= 1'b0;
            rx_hold--;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one item and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        last    <= fin;
        do @(posedge clk); while (full);
        tokenize_byte(b, fin);
        bytes_sent++;
    endtask

    // Stop sending, wait for every predicted result, then let the pipe settle
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_DELIM_CHARS: sep_set    = val;
            REG_DELIM_COUNT: sep_cnt    = val[3:0];
            REG_OPEN_CHARS:  opener_set = val[31:0];
            REG_OPEN_COUNT:  opener_cnt = val[2:0];
            REG_CLOSE_CHARS: closer_set = val[31:0];
            REG_CLOSE_COUNT: closer_cnt = val[2:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [63:0] seps, input logic [3:0] n_seps,
                               input logic [31:0] opens, input logic [2:0] n_opens,
                               input logic [31:0] closes, input logic [2:0] n_closes);
        wait_drained();
        write_reg(REG_DELIM_CHARS, seps);
        write_reg(REG_DELIM_COUNT, 64'(n_seps));
        write_reg(REG_OPEN_CHARS, 64'(opens));
        write_reg(REG_OPEN_COUNT, 64'(n_opens));
        write_reg(REG_CLOSE_CHARS, 64'(closes));
        write_reg(REG_CLOSE_COUNT, 64'(n_closes));
        cfg_we <= 1'b0;
    endtask

    // Draw eight bytes, mostly from a narrow alphabet so that sets overlap
    function automatic logic [63:0] pick_charset();
        logic [63:0] w;
        for (int k = 0; k < 8; k++)
            case ($urandom_range(7))
                0:       w[k*8 +: 8] = 8'h00;
                1, 2:    w[k*8 +: 8] = 8'($urandom);
                default: w[k*8 +: 8] = 8'h20 + 8'($urandom_range(15));
            endcase
        return w;
    endfunction

    // Draw a string byte weighted toward the configured special bytes
    function automatic logic [7:0] pick_byte();
        int r;
        int k;
        r = $urandom_range(99);
        k = $urandom_range(7);
        if (r < 35)
            return sep_set[k*8 +: 8];
        if (r < 47)
            return opener_set[(k % 4)*8 +: 8];
        if (r < 59)
            return closer_set[(k % 4)*8 +: 8];
        if (r < 64)
            return 8'h00;
        if (r < 82)
            return 8'h20 + 8'($urandom_range(15));
        return 8'($urandom);
    endfunction

    // Send one string: mostly well formed, sometimes noise with random ends
    task automatic send_random_string();
        int         len;
        logic       noise;
        logic [7:0] b;
        logic       fin;
        noise = ($urandom_range(99) < 15);
        len   = $urandom_range(1, 16);
        for (int i = 0; i < len; i++)
        begin
            if (noise)
            begin
                b   = 8'($urandom);
                fin = ($urandom_range(7) == 0);
            end
            else
            begin
                b   = pick_byte();
                fin = (i == len - 1);
            end
            send_byte(b, fin);
        end
    endtask

    // Reset settings: no delimiters, no groups, every byte passes
    task automatic test_passthrough();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    // Leading delimiter, a run of delimiters, delimiter as final byte
    task automatic test_delimiters();
        load_config(64'h0000_0000_0020_3B2C, 4'd3, 32'h0, 3'd0, 32'h0, 3'd0);
        send_byte(8'h2C, 1'b0);
        send_byte(8'h2C, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h3B, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h20, 1'b1);
    endtask

    // Groups: opener that is also a delimiter, duplicate openers,
    // group past the close count, final byte with a pending token
    task automatic test_groups();
        load_config(64'h0000_0000_0000_2820, 4'd2,
                    32'h3C5B_5B28, 3'd4, 32'h3E7D_5D29, 3'd2);
        send_byte(8'h28, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h28, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h29, 1'b0);
        send_byte(8'h5B, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(8'h5D, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h3E, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5B, 1'b0);
        send_byte(8'h77, 1'b1);
    endtask

    // Counts above capacity, and writes to unmapped indexes
    task automatic test_capacity();
        load_config(64'h4847_4645_4443_4241, 4'd15,
                    32'h7B5B_283C, 3'd7, 32'h7D5D_293E, 3'd7);
        @(posedge clk);
        write_reg(IDX_UNMAPPED_LO, '1);
        write_reg(IDX_UNMAPPED_HI, '0);
        cfg_we <= 1'b0;
        send_byte(8'h78, 1'b0);
        send_byte(8'h48, 1'b0);
        send_byte(8'h7B, 1'b0);
        send_byte(8'h7D, 1'b1);
    endtask

    // Hold the receiver off while the sender keeps offering items
    task automatic test_backpressure();
        int target;
        wait_drained();
        tx_idle_pct = 0;
        rx_hold     = HOLD_CYCLES;
        target      = bytes_sent + 40;
        while (bytes_sent < target)
            send_random_string();
        tx_idle_pct = IDLE_PCT;
    endtask

    // Random strings under a series of settings, extremes included
    task automatic test_random_strings();
        int target;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: load_config(pick_charset(), 4'd15, pick_charset(), 3'd7,
                               pick_charset(), 3'd7);
                1: load_config('1, 4'd8, '1, 3'd0, '0, 3'd0);
                2: load_config(pick_charset(), 4'd8, pick_charset(), 3'd4,
                               pick_charset(), 3'd4);
                5: load_config(pick_charset(), 4'd0, pick_charset(), 3'd0,
                               pick_charset(), 3'd0);
                default: load_config(pick_charset(), 4'($urandom_range(15)),
                                     pick_charset(), 3'($urandom_range(7)),
                                     pick_charset(), 3'($urandom_range(7)));
            endcase
            // One phase runs with no idling on either side
            tx_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            rx_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                send_random_string();
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_delimiters();
        test_groups();
        test_capacity();
        test_backpressure();
        test_random_strings();
        wait_drained();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/dgt_pkg.sv
rtl/core/dgt_front.sv
rtl/core/dgt_queue.sv
rtl/core/dgt_back.sv
rtl/core/delimiter_group_tokenizer.sv
bench/tb.sv
